/* rtl/core/pls_pkg.sv */
// Shared constants, operation and status codes, and controller/datapath
// handshake structs for the positional list store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int FW    = 2;
  localparam int PW    = 8;
  localparam int DW    = 32;
  localparam int SW    = 2;
  localparam int LW    = 7;
  localparam int CMPW  = ((PW > CW) ? PW : CW) + 1;

  localparam logic [FW-1:0] FN_INSERT = 2'd0;
  localparam logic [FW-1:0] FN_DELETE = 2'd1;
  localparam logic [FW-1:0] FN_READ   = 2'd2;
  localparam logic [FW-1:0] FN_CLEAR  = 2'd3;

  localparam logic [SW-1:0] ST_OK    = 2'd0;
  localparam logic [SW-1:0] ST_RANGE = 2'd1;
  localparam logic [SW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic          latch;
    logic          ld_ins;
    logic          ld_del;
    logic          rd_shift;
    logic          rd_pos;
    logic          wr_value;
    logic          cnt_inc;
    logic          cnt_dec;
    logic          cnt_clr;
    logic          finish;
    logic          use_rd;
    logic [SW-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic [FW-1:0] func;
    logic          range_err;
    logic          full;
    logic          has_moves;
    logic          last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/pls_dp.sv */
// Datapath of the positional list store: request registers, entry memory,
// length counter, shift pointer and result registers. Depends on pls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pls_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pls_pkg::cmd_t                cmd_i,
  output pls_pkg::sts_t                     sts_o,
  input  wire logic [pls_pkg::FW-1:0]       func_i,
  input  wire logic [pls_pkg::PW-1:0]       pos_i,
  input  wire logic signed [pls_pkg::DW-1:0] value_i,
  output logic                              done_o,
  output logic [pls_pkg::SW-1:0]            status_o,
  output logic signed [pls_pkg::DW-1:0]     read_value_o,
  output logic [pls_pkg::LW-1:0]            length_o
);

  logic [pls_pkg::DW-1:0] mem [pls_pkg::DEPTH];

  logic [pls_pkg::FW-1:0]   func_q;
  logic [pls_pkg::PW-1:0]   pos_q;
  logic [pls_pkg::DW-1:0]   value_q;
  logic [pls_pkg::CW-1:0]   count_q, count_d;
  logic [pls_pkg::AW-1:0]   ptr_q, ptr_d;
  logic [pls_pkg::AW-1:0]   wa_q;
  logic                     wv_q;
  logic [pls_pkg::DW-1:0]   rd_q;
  logic                     done_q;
  logic [pls_pkg::SW-1:0]   status_q;
  logic [pls_pkg::DW-1:0]   read_value_q;
  logic [pls_pkg::LW-1:0]   length_q;

  logic                     is_ins;
  logic [pls_pkg::AW-1:0]   pos_m1, cnt_m1;
  logic [pls_pkg::CMPW-1:0] pos_x, cnt_x;
  logic                     pos_zero;
  logic                     we, re;
  logic [pls_pkg::AW-1:0]   wa, ra;
  logic [pls_pkg::DW-1:0]   wd;

  assign is_ins   = (func_q == pls_pkg::FN_INSERT);
  assign pos_m1   = pls_pkg::AW'(pos_q - pls_pkg::PW'(1));
  assign cnt_m1   = pls_pkg::AW'(count_q - pls_pkg::CW'(1));
  assign pos_x    = pls_pkg::CMPW'(pos_q);
  assign cnt_x    = pls_pkg::CMPW'(count_q);
  assign pos_zero = (pos_q == '0);

  always_comb begin
    sts_o.func = func_q;
    if (is_ins) begin
      sts_o.range_err = pos_zero || (pos_x > cnt_x + pls_pkg::CMPW'(1));
      sts_o.has_moves = (pos_x <= cnt_x);
      sts_o.last      = (ptr_q == pos_m1);
    end else begin
      sts_o.range_err = pos_zero || (pos_x > cnt_x);
      sts_o.has_moves = (pos_x < cnt_x);
      sts_o.last      = (ptr_q == cnt_m1);
    end
    sts_o.full = (cnt_x >= pls_pkg::CMPW'(pls_pkg::DEPTH));
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + pls_pkg::CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - pls_pkg::CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ld_ins) begin
      ptr_d = cnt_m1;
    end else if (cmd_i.ld_del) begin
      ptr_d = pls_pkg::AW'(pos_q);
    end else if (cmd_i.rd_shift) begin
      ptr_d = is_ins ? ptr_q - pls_pkg::AW'(1) : ptr_q + pls_pkg::AW'(1);
    end
  end

  assign we = wv_q | cmd_i.wr_value;
  assign wa = cmd_i.wr_value ? pos_m1 : wa_q;
  assign wd = cmd_i.wr_value ? value_q : rd_q;
  assign re = cmd_i.rd_shift | cmd_i.rd_pos;
  assign ra = cmd_i.rd_pos ? pos_m1 : ptr_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= func_i;
      pos_q   <= pos_i;
      value_q <= value_i;
    end
    if (cmd_i.rd_shift) begin
      wa_q <= is_ins ? ptr_q + pls_pkg::AW'(1) : ptr_q - pls_pkg::AW'(1);
    end
    ptr_q <= ptr_d;
    if (cmd_i.finish) begin
      status_q     <= cmd_i.st;
      read_value_q <= cmd_i.use_rd ? rd_q : '0;
      length_q     <= pls_pkg::LW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      wv_q    <= cmd_i.rd_shift;
      done_q  <= cmd_i.finish;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = read_value_q;
  assign length_o     = length_q;

endmodule

`default_nettype wire

/* rtl/core/pls_ctrl.sv */
// Controller state machine of the positional list store: sequences checks,
// entry shifts and result issue through commands. Depends on pls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire pls_pkg::sts_t sts_i,
  output pls_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_WRVAL  = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts_i.func)
          pls_pkg::FN_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.finish  = 1'b1;
            cmd_o.st      = pls_pkg::ST_OK;
            state_d       = S_IDLE;
          end
          pls_pkg::FN_READ: begin
            if (sts_i.range_err) begin
              cmd_o.finish = 1'b1;
              cmd_o.st     = pls_pkg::ST_RANGE;
              state_d      = S_IDLE;
            end else begin
              cmd_o.rd_pos = 1'b1;
              state_d      = S_RDWAIT;
            end
          end
          pls_pkg::FN_DELETE: begin
            if (sts_i.range_err) begin
              cmd_o.finish = 1'b1;
              cmd_o.st     = pls_pkg::ST_RANGE;
              state_d      = S_IDLE;
            end else if (sts_i.has_moves) begin
              cmd_o.ld_del = 1'b1;
              state_d      = S_SHIFT;
            end else begin
              cmd_o.cnt_dec = 1'b1;
              cmd_o.finish  = 1'b1;
              cmd_o.st      = pls_pkg::ST_OK;
              state_d       = S_IDLE;
            end
          end
          pls_pkg::FN_INSERT: begin
            if (sts_i.range_err) begin
              cmd_o.finish = 1'b1;
              cmd_o.st     = pls_pkg::ST_RANGE;
              state_d      = S_IDLE;
            end else if (sts_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.st     = pls_pkg::ST_FULL;
              state_d      = S_IDLE;
            end else if (sts_i.has_moves) begin
              cmd_o.ld_ins = 1'b1;
              state_d      = S_SHIFT;
            end else begin
              state_d = S_WRVAL;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.rd_shift = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.func == pls_pkg::FN_INSERT) begin
          state_d = S_WRVAL;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.finish  = 1'b1;
          cmd_o.st      = pls_pkg::ST_OK;
          state_d       = S_IDLE;
        end
      end
      S_WRVAL: begin
        cmd_o.wr_value = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.finish   = 1'b1;
        cmd_o.st       = pls_pkg::ST_OK;
        state_d        = S_IDLE;
      end
      S_RDWAIT: begin
        cmd_o.finish = 1'b1;
        cmd_o.use_rd = 1'b1;
        cmd_o.st     = pls_pkg::ST_OK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* rtl/core/positional_list_store.sv */
// Top level of the positional list store: joins the controller and the
// datapath. Depends on pls_pkg, pls_ctrl and pls_dp.
`timescale 1ns / 1ps
`default_nettype none

// A request transfers on a clock edge with start high and busy low, and
// exactly one result follows, shown for a single cycle with done_o high; the
// receiver cannot stall it, so it must take every result in that cycle.
// The entries live in a single memory with one write and one registered read
// port, and insert and delete move the later entries one per cycle through
// that port pair. Clear, rejected requests and a delete of the last entry finish
// in the check state, a read after a wait for the registered read, an append
// after writing the value, a delete after the shift and drain states, and an
// insert that moves entries after shift, drain and the value write; busy
// stays high through the cycle before the result and is low in the result
// cycle, so the next request can transfer at its closing edge.

module positional_list_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pls_pkg::FW-1:0]        func_i,
  input  wire logic [pls_pkg::PW-1:0]        pos_i,
  input  wire logic signed [pls_pkg::DW-1:0] value_i,
  output logic                               done_o,
  output logic [pls_pkg::SW-1:0]             status_o,
  output logic signed [pls_pkg::DW-1:0]      read_value_o,
  output logic [pls_pkg::LW-1:0]             length_o
);

  pls_pkg::cmd_t cmd;
  pls_pkg::sts_t sts;

  pls_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  pls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .pos_i        (pos_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .length_o     (length_o)
  );

endmodule

`default_nettype wire

/* sim/positional_list_store_tb.sv */
// Self-checking testbench for positional_list_store: directed and random
// insert, delete, read and clear requests checked against a local list model.
// Depends on pls_pkg and the positional_list_store RTL.
`timescale 1ns / 1ps

module positional_list_store_tb;
  import pls_pkg::*;

  typedef struct {
    logic [SW-1:0]        status;
    logic signed [DW-1:0] read_value;
    logic [LW-1:0]        length;
  } list_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [FW-1:0]        func_i;
  logic [PW-1:0]        pos_i;
  logic signed [DW-1:0] value_i;
  logic                 done_o;
  logic [SW-1:0]        status_o;
  logic signed [DW-1:0] read_value_o;
  logic [LW-1:0]        length_o;

  logic signed [DW-1:0] list_words [DEPTH];
  int                   list_len;
  list_result_t         pending_results [$];
  int                   error_count;
  int                   gaps_enabled;
  int                   op_seen [4];
  int                   status_seen [3];
  int                   peak_len;
  int                   results_checked;

  positional_list_store DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .pos_i        (pos_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .length_o     (length_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Applies one request to the list model and returns the result it must produce.
  function automatic list_result_t apply_request(input logic [FW-1:0] fn,
                                                 input logic [PW-1:0] pos,
                                                 input logic signed [DW-1:0] val);
    list_result_t r;
    int           p;
    int           i;
    p = int'(pos);
    r.status = ST_OK;
    r.read_value = '0;
    case (fn)
      FN_INSERT: begin
        if (p == 0 || p > list_len + 1) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = val;
          list_len++;
        end
      end
      FN_DELETE: begin
        if (p == 0 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      FN_READ: begin
        if (p == 0 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_words[p-1];
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.length = LW'(list_len);
    return r;
  endfunction

  task automatic send_request(input logic [FW-1:0] fn, input logic [PW-1:0] pos,
                              input logic signed [DW-1:0] val);
    int gap;
    gap = 0;
    if (gaps_enabled != 0 && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    func_i  <= fn;
    pos_i   <= pos;
    value_i <= val;
    while (busy !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(apply_request(fn, pos, val));
    op_seen[fn]++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (status %0d length %0d)",
                                  status_o, length_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o < 3) status_seen[status_o]++;
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (read_value_o !== want.read_value)
          report_mismatch($sformatf("read_value %0d, expected %0d",
                                    read_value_o, want.read_value));
        if (length_o !== want.length)
          report_mismatch($sformatf("length %0d, expected %0d", length_o, want.length));
      end
    end
  end

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return (($urandom_range(0, 1) == 0) ? 32'sh0 : -32'sd1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PW-1:0] pick_pos(input logic [FW-1:0] fn);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 20) return PW'($urandom_range(0, 255));
    if (fn == FN_INSERT) return PW'($urandom_range(1, list_len + 1));
    if (list_len == 0) return PW'($urandom_range(0, 3));
    return PW'($urandom_range(1, list_len));
  endfunction

  task automatic test_bounds_and_basics();
    send_request(FN_READ, 8'd1, 32'sd5);
    send_request(FN_DELETE, 8'd1, 32'sd5);
    send_request(FN_INSERT, 8'd0, 32'sd7);
    send_request(FN_INSERT, 8'd2, 32'sd7);
    send_request(FN_CLEAR, 8'd255, -32'sd1);
    send_request(FN_INSERT, 8'd1, 32'sh7FFF_FFFF);
    send_request(FN_INSERT, 8'd2, 32'sh8000_0000);
    send_request(FN_INSERT, 8'd1, 32'sh0);
    send_request(FN_INSERT, 8'd2, -32'sd1);
    send_request(FN_READ, 8'd0, 32'sd0);
    for (int p = 1; p <= 5; p++) send_request(FN_READ, PW'(p), 32'sd0);
    send_request(FN_INSERT, 8'd6, 32'sh5555_5555);
    send_request(FN_INSERT, 8'd5, 32'sh5555_5555);
    send_request(FN_DELETE, 8'd0, 32'sd0);
    send_request(FN_DELETE, 8'd6, 32'sd0);
    send_request(FN_DELETE, 8'd3, 32'sd0);
    send_request(FN_DELETE, 8'd4, 32'sd0);
    send_request(FN_READ, 8'd255, 32'sd0);
    send_request(FN_READ, 8'd3, 32'sd0);
    send_request(FN_CLEAR, 8'd0, 32'sh2AAA_AAAA);
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH) send_request(FN_INSERT, pick_pos(FN_INSERT), pick_value());
    send_request(FN_INSERT, PW'(DEPTH + 1), 32'sd1);
    send_request(FN_INSERT, 8'd1, 32'sd1);
    send_request(FN_INSERT, PW'(DEPTH + 2), 32'sd1);
    send_request(FN_INSERT, 8'd0, 32'sd1);
    send_request(FN_READ, PW'(DEPTH), 32'sd0);
    send_request(FN_DELETE, PW'(DEPTH), 32'sd0);
    send_request(FN_INSERT, PW'(DEPTH), 32'sh1234_5678);
    send_request(FN_DELETE, 8'd1, 32'sd0);
    send_request(FN_INSERT, PW'(DEPTH), -32'sd2);
    send_request(FN_READ, PW'(DEPTH), 32'sd0);
    send_request(FN_READ, PW'(DEPTH + 1), 32'sd0);
    repeat (8) send_request(FN_READ, pick_pos(FN_READ), pick_value());
  endtask

  // The list is pushed alternately toward full and toward empty so that every length
  // and every shift distance is exercised.
  task automatic run_random_mix(input int n_items);
    int            growing;
    int            r;
    logic [FW-1:0] fn;
    growing = 1;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 59) == 0) growing = 1 - growing;
      if (list_len == DEPTH && $urandom_range(0, 3) == 0) growing = 0;
      if (list_len == 0) growing = 1;
      r = $urandom_range(0, 99);
      if (r < 2) fn = FN_CLEAR;
      else if (r < (growing != 0 ? 55 : 20)) fn = FN_INSERT;
      else if (r < 75) fn = FN_DELETE;
      else fn = FN_READ;
      send_request(fn, pick_pos(fn), pick_value());
    end
  endtask

  task automatic test_random_with_gaps();
    gaps_enabled = 1;
    run_random_mix(400);
  endtask

  task automatic test_back_to_back();
    gaps_enabled = 0;
    run_random_mix(100);
  endtask

  initial begin : stimulus
    int waited;
    error_count     = 0;
    results_checked = 0;
    peak_len        = 0;
    list_len        = 0;
    gaps_enabled    = 1;
    op_seen         = '{default: 0};
    status_seen     = '{default: 0};
    foreach (list_words[i]) list_words[i] = '0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    func_i  = FN_READ;
    pos_i   = '0;
    value_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_bounds_and_basics();
    test_full_list();
    test_random_with_gaps();
    test_back_to_back();

    @(negedge clk_i);
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      void'(pending_results.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("Checked %0d results: %0d inserts, %0d deletes, %0d reads, %0d clears.",
             results_checked, op_seen[FN_INSERT], op_seen[FN_DELETE], op_seen[FN_READ],
             op_seen[FN_CLEAR]);
    $display("Status ok/range/full seen %0d/%0d/%0d times; longest list %0d entries.",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL], peak_len);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pls_pkg.sv
rtl/core/pls_dp.sv
rtl/core/pls_ctrl.sv
rtl/core/positional_list_store.sv
sim/positional_list_store_tb.sv
